FILE: rtl/assert_macros.svh
// Assertion macros shared by the checker files of this project.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

FILE: rtl/rdcw_pkg.sv
// Package for the range distinct-count window unit: field widths, opcodes,
// default sizes and the command struct of the tally part. Depends on nothing.
package rdcw_pkg;

   // Default sizes handed to the top level parameters.
   localparam int LENGTH_DEF = 1024;
   localparam int VALUES_DEF = 4096;

   // Fixed widths of the item fields.
   localparam int INDEX_W = 10;
   localparam int VALUE_W = 12;
   localparam int COUNT_W = 11;

   // Opcodes of an input item.
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Commands to the occurrence tally.
   typedef struct packed {
      logic clear; // zero the entry at the address
      logic rd;    // read the entry at the address
      logic upd;   // write back the entry read last, adjusted
      logic add;   // adjustment direction: one for add, zero for remove
   } tally_cmd_type;

endpackage

FILE: rtl/rdcw_tally.sv
// Occurrence count memory with the distinct-value total.
// Depends on rdcw_pkg for the command struct.
module rdcw_tally #(
   parameter int LENGTH = 1024,
   parameter int VALUES = 4096
) (
   input  logic                           clock,
   input  logic                           reset,
   input  rdcw_pkg::tally_cmd_type        cmd,
   input  logic [$clog2(VALUES)-1:0]      addr,
   output logic [$clog2(LENGTH+1)-1:0]    total
);
   import rdcw_pkg::*;

   localparam int VAL_W = $clog2(VALUES);
   localparam int CNT_W = $clog2(LENGTH + 1);

   logic [CNT_W-1:0] count_mem [VALUES];
   logic [CNT_W-1:0] rdata_ff;
   logic [VAL_W-1:0] addr_ff;
   logic [CNT_W-1:0] total_ff;
   logic [CNT_W-1:0] total_in;
   logic [CNT_W-1:0] cnt_new;

   // New count and total for an add or a remove of the value read last.
   always_comb begin
      cnt_new  = rdata_ff;
      total_in = total_ff;
      if (cmd.upd) begin
         if (cmd.add) begin
            cnt_new = rdata_ff + 1'b1;
            if (rdata_ff == '0) begin
               total_in = total_ff + 1'b1;
            end
         end else if (rdata_ff != '0) begin
            cnt_new = rdata_ff - 1'b1;
            if (rdata_ff == CNT_W'(1) && total_ff != '0) begin
               total_in = total_ff - 1'b1;
            end
         end
      end
   end

   // Memory: one read port with registered data, one write port.
   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         rdata_ff <= count_mem[addr];
         addr_ff  <= addr;
      end
      if (cmd.clear) begin
         count_mem[addr] <= '0;
      end else if (cmd.upd) begin
         count_mem[addr_ff] <= cnt_new;
      end
   end

   // Distinct total.
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else begin
         total_ff <= total_in;
      end
   end

   assign total = total_ff;

endmodule

FILE: rtl/range_distinct_count_window_unit.sv
// Top level of the range distinct-count window unit: sequencer and position memory.
// Depends on rdcw_pkg and rdcw_tally.
//
// Usage: items arrive on the req_ channel (valid/ready). A write item
// (opcode zero) stores value at position index; a query item (opcode one)
// moves the window to [index, right_end] and returns one item on the rsp_
// channel holding the number of distinct values in the window.
// Flow: the unit handles one item at a time. A write stores the value and,
// when the position lies in the window, removes the old value from the
// count memory and adds the new one. A query walks the positions from the
// lower to the higher of the old and new window bounds; each position that
// enters or leaves also gets a read-modify-write of its count, and the
// result is loaded at the end of the walk. The walk is set by the single read port of the
// position memory and the read-modify-write of the count memory.
// A reversed or out-of-array range answers zero.
// Reset: a clearing pass zeroes both memories, one entry a cycle;
// req_ready is low meanwhile.
// Stalls: the result sits in an output register; a new item is taken while
// it waits, but a further result waits until rsp_ready takes the first.
module range_distinct_count_window_unit #(
   parameter int LENGTH = rdcw_pkg::LENGTH_DEF,
   parameter int VALUES = rdcw_pkg::VALUES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_opcode,
   input  logic [rdcw_pkg::INDEX_W-1:0]  req_index,
   input  logic [rdcw_pkg::INDEX_W-1:0]  req_right_end,
   input  logic [rdcw_pkg::VALUE_W-1:0]  req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rdcw_pkg::COUNT_W-1:0]  rsp_distinct_count
);
   import rdcw_pkg::*;

   localparam int POS_W = $clog2(LENGTH);
   localparam int VAL_W = $clog2(VALUES);
   localparam int CNT_W = $clog2(LENGTH + 1);
   localparam int MAX_D = (LENGTH > VALUES) ? LENGTH : VALUES;
   localparam int CLR_W = $clog2(MAX_D);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_Q_SCAN, ST_Q_UPD, ST_FIN,
      ST_W_CHK, ST_W_REM, ST_W_ADD, ST_W_ADDU
   } state_type;

   state_type          state_ff, state_in;
   logic [CLR_W-1:0]   clr_ff, clr_in;
   logic [POS_W-1:0]   p_ff, p_in;
   logic [POS_W-1:0]   hi_ff, hi_in;
   logic [POS_W-1:0]   qlo_ff, qlo_in;
   logic [POS_W-1:0]   qhi_ff, qhi_in;
   logic [POS_W-1:0]   wl_ff, wl_in;
   logic [POS_W-1:0]   wr_ff, wr_in;
   logic               empty_ff, empty_in;
   logic [VAL_W-1:0]   wv_ff, wv_in;
   logic               add_ff, add_in;
   logic               zero_ff, zero_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   // Position memory: bit VAL_W is the in-window bit, the rest the value.
   logic [VAL_W:0]     pos_mem [LENGTH];
   logic [VAL_W:0]     pos_rdata_ff;
   logic [POS_W-1:0]   pos_raddr;
   logic               pos_we;
   logic [POS_W-1:0]   pos_waddr;
   logic [VAL_W:0]     pos_wdata;

   tally_cmd_type      tcmd;
   logic [VAL_W-1:0]   t_addr;
   logic [CNT_W-1:0]   total;

   // Decoded request fields.
   logic               idx_ok;
   logic [VAL_W-1:0]   val_sat;
   logic [POS_W-1:0]   q_left;
   logic [POS_W-1:0]   q_right;
   logic               q_bad;
   logic [POS_W-1:0]   scan_lo;
   logic [POS_W-1:0]   scan_hi;
   logic               want;
   logic               iw;

   rdcw_tally #(
      .LENGTH (LENGTH),
      .VALUES (VALUES)
   ) u_tally (
      .clock (clock),
      .reset (reset),
      .cmd   (tcmd),
      .addr  (t_addr),
      .total (total)
   );

   // Field decoding: saturation, range checks and the scan bounds.
   always_comb begin
      idx_ok  = 32'(req_index) < 32'(LENGTH);
      val_sat = (32'(req_value) >= 32'(VALUES)) ? VAL_W'(VALUES - 1) : VAL_W'(req_value);
      q_right = (32'(req_right_end) >= 32'(LENGTH)) ? POS_W'(LENGTH - 1)
                                                    : POS_W'(req_right_end);
      q_bad   = 32'(req_index) > 32'(q_right);
      q_left  = POS_W'(req_index);
      // Outside the union of the old and the new window nothing changes.
      if (empty_ff) begin
         scan_lo = q_left;
         scan_hi = q_right;
      end else begin
         scan_lo = (q_left < wl_ff) ? q_left : wl_ff;
         scan_hi = (q_right > wr_ff) ? q_right : wr_ff;
      end
      want = (p_ff >= qlo_ff) && (p_ff <= qhi_ff);
      iw   = pos_rdata_ff[VAL_W];
   end

   // Sequencer next state and memory control.
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      p_in         = p_ff;
      hi_in        = hi_ff;
      qlo_in       = qlo_ff;
      qhi_in       = qhi_ff;
      wl_in        = wl_ff;
      wr_in        = wr_ff;
      empty_in     = empty_ff;
      wv_in        = wv_ff;
      add_in       = add_ff;
      zero_in      = zero_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_count_in = rsp_count_ff;
      req_ready    = 1'b0;
      pos_raddr    = p_ff;
      pos_we       = 1'b0;
      pos_waddr    = p_ff;
      pos_wdata    = pos_rdata_ff;
      tcmd         = '0;
      t_addr       = pos_rdata_ff[VAL_W-1:0];

      case (state_ff)
         // Zero both memories after reset.
         ST_CLEAR: begin
            tcmd.clear = 1'b1;
            t_addr     = clr_ff[VAL_W-1:0];
            if (32'(clr_ff) < 32'(LENGTH)) begin
               pos_we    = 1'b1;
               pos_waddr = clr_ff[POS_W-1:0];
               pos_wdata = '0;
            end
            if (32'(clr_ff) == 32'(MAX_D - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end

         // Take an item and start its work.
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_opcode == OP_WRITE) begin
                  if (idx_ok) begin
                     wv_in     = val_sat;
                     p_in      = q_left;
                     pos_raddr = q_left;
                     state_in  = ST_W_CHK;
                  end
               end else if (q_bad) begin
                  zero_in  = 1'b1;
                  state_in = ST_FIN;
               end else begin
                  zero_in   = 1'b0;
                  qlo_in    = q_left;
                  qhi_in    = q_right;
                  p_in      = scan_lo;
                  hi_in     = scan_hi;
                  pos_raddr = scan_lo;
                  wl_in     = q_left;
                  wr_in     = q_right;
                  empty_in  = 1'b0;
                  state_in  = ST_Q_SCAN;
               end
            end
         end

         // Compare each position's membership with the new window.
         ST_Q_SCAN: begin
            if (iw != want) begin
               pos_we    = 1'b1;
               pos_wdata = {want, pos_rdata_ff[VAL_W-1:0]};
               tcmd.rd   = 1'b1;
               add_in    = want;
               state_in  = ST_Q_UPD;
            end else if (p_ff == hi_ff) begin
               state_in = ST_FIN;
            end else begin
               p_in      = p_ff + 1'b1;
               pos_raddr = p_ff + 1'b1;
            end
         end

         // Write back the count while the next position is read.
         ST_Q_UPD: begin
            tcmd.upd = 1'b1;
            tcmd.add = add_ff;
            if (p_ff == hi_ff) begin
               state_in = ST_FIN;
            end else begin
               p_in      = p_ff + 1'b1;
               pos_raddr = p_ff + 1'b1;
               state_in  = ST_Q_SCAN;
            end
         end

         // Load the result once the output register is free.
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = zero_ff ? '0 : COUNT_W'(total);
               state_in     = ST_IDLE;
            end
         end

         // Store the new value; a position in the window swaps its count.
         ST_W_CHK: begin
            pos_we    = 1'b1;
            pos_wdata = {iw, wv_ff};
            if (iw) begin
               tcmd.rd  = 1'b1;
               state_in = ST_W_REM;
            end else begin
               state_in = ST_IDLE;
            end
         end

         ST_W_REM: begin
            tcmd.upd = 1'b1;
            tcmd.add = 1'b0;
            state_in = ST_W_ADD;
         end

         ST_W_ADD: begin
            tcmd.rd  = 1'b1;
            t_addr   = wv_ff;
            state_in = ST_W_ADDU;
         end

         ST_W_ADDU: begin
            tcmd.upd = 1'b1;
            tcmd.add = 1'b1;
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         empty_ff     <= 1'b1;
         wl_ff        <= '0;
         wr_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         empty_ff     <= empty_in;
         wl_ff        <= wl_in;
         wr_ff        <= wr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers and the result payload.
   always_ff @(posedge clock) begin
      p_ff         <= p_in;
      hi_ff        <= hi_in;
      qlo_ff       <= qlo_in;
      qhi_ff       <= qhi_in;
      wv_ff        <= wv_in;
      add_ff       <= add_in;
      zero_ff      <= zero_in;
      rsp_count_ff <= rsp_count_in;
   end

   // Position memory: registered read, one write port.
   always_ff @(posedge clock) begin
      pos_rdata_ff <= pos_mem[pos_raddr];
      if (pos_we) begin
         pos_mem[pos_waddr] <= pos_wdata;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_distinct_count = rsp_count_ff;

endmodule

FILE: rtl/rdcw_checker.sv
// Port-level checks for the range distinct-count window unit, with its bind.
// Depends on rdcw_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rdcw_checker #(
   parameter int LENGTH = rdcw_pkg::LENGTH_DEF
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          req_opcode,
   input logic [rdcw_pkg::INDEX_W-1:0]  req_index,
   input logic [rdcw_pkg::INDEX_W-1:0]  req_right_end,
   input logic [rdcw_pkg::VALUE_W-1:0]  req_value,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [rdcw_pkg::COUNT_W-1:0]  rsp_distinct_count
);
   import rdcw_pkg::*;

   logic req_take;

   assign req_take = req_valid && req_ready;

   // The clearing pass holds off items right after reset.
   `ASSERT_IMPLIES(a_clear_after_reset, clock, 1'b0, $past(reset) && !reset, !req_ready)

   // A query occupies the unit, so the next cycle takes no item.
   `ASSERT_NEXT(a_query_busy, clock, reset, req_take && req_opcode == OP_QUERY, !req_ready)

   // A write never produces a result item.
   `ASSERT_NEXT(a_write_silent, clock, reset,
                req_take && req_opcode == OP_WRITE && !rsp_valid, !rsp_valid)

   // A waiting result item holds its count.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
                rsp_valid && $stable(rsp_distinct_count))

   // No window holds more distinct values than positions.
   `ASSERT_IMPLIES(a_count_bound, clock, reset, rsp_valid,
                   32'(rsp_distinct_count) <= 32'(LENGTH))

endmodule

bind range_distinct_count_window_unit rdcw_checker #(.LENGTH(LENGTH)) u_rdcw_checker (.*);

FILE: tb/range_distinct_count_window_unit_tb.sv
// Testbench for the range distinct-count window unit: a self-checking run of
// directed and random write and query items against a predicted window state.
// Depends on rdcw_pkg and the range_distinct_count_window_unit RTL.

// Tracks the array, the per-value tallies and the window membership, and
// holds the distinct counts still due on the result channel.
class distinct_window_board;
   typedef bit [rdcw_pkg::VALUE_W-1:0] value_type;

   value_type                  value_mem [rdcw_pkg::LENGTH_DEF];
   bit [rdcw_pkg::COUNT_W-1:0] tally [rdcw_pkg::VALUES_DEF];
   bit                         member [rdcw_pkg::LENGTH_DEF];
   bit [rdcw_pkg::COUNT_W-1:0] distinct;
   bit [rdcw_pkg::COUNT_W-1:0] expected_counts [$];
   int mismatches;
   int checked;
   int writes;
   int queries;
   int reversed;

   function void add_value(bit [rdcw_pkg::VALUE_W-1:0] val);
      if (tally[val] == 0)
         distinct++;
      tally[val]++;
   endfunction

   function void drop_value(bit [rdcw_pkg::VALUE_W-1:0] val);
      if (tally[val] != 0) begin
         tally[val]--;
         if (tally[val] == 0 && distinct != 0)
            distinct--;
      end
   endfunction

   // Notes one accepted item and updates the predicted state.
   function void take_request(logic op, logic [rdcw_pkg::INDEX_W-1:0] idx,
                              logic [rdcw_pkg::INDEX_W-1:0] rgt,
                              logic [rdcw_pkg::VALUE_W-1:0] val);
      int unsigned top;
      value_type   wval;
      if (op == rdcw_pkg::OP_WRITE) begin
         writes++;
         if (idx >= rdcw_pkg::LENGTH_DEF)
            return;
         wval = (val >= rdcw_pkg::VALUES_DEF) ? value_type'(rdcw_pkg::VALUES_DEF - 1) : val;
         // A position inside the window swaps its old value for the new one.
         if (member[idx]) begin
            drop_value(value_mem[idx]);
            value_mem[idx] = wval;
            add_value(wval);
         end else begin
            value_mem[idx] = wval;
         end
      end else begin
         queries++;
         top = (rgt >= rdcw_pkg::LENGTH_DEF) ? rdcw_pkg::LENGTH_DEF - 1 : rgt;
         if (idx > top) begin
            // A reversed range answers zero and leaves the window alone.
            reversed++;
            expected_counts.push_back('0);
         end else begin
            // Flip every position whose membership disagrees with the new range.
            for (int p = 0; p < rdcw_pkg::LENGTH_DEF; p++) begin
               if (member[p] != (p >= idx && p <= top)) begin
                  if (member[p])
                     drop_value(value_mem[p]);
                  else
                     add_value(value_mem[p]);
                  member[p] = !member[p];
               end
            end
            expected_counts.push_back(distinct);
         end
      end
   endfunction

   task report_mismatch(string msg);
      mismatches++;
      $display("mismatch: %s", msg);
   endtask

   // Compares one accepted result item with the oldest count still due.
   task check_count(logic [rdcw_pkg::COUNT_W-1:0] got);
      bit [rdcw_pkg::COUNT_W-1:0] want;
      if (expected_counts.size() == 0) begin
         report_mismatch($sformatf("distinct count %0d arrived with none due", got));
      end else begin
         want = expected_counts.pop_front();
         checked++;
         if (got !== want)
            report_mismatch($sformatf("distinct count %0d, predicted %0d", got, want));
      end
   endtask
endclass

module range_distinct_count_window_unit_tb;
   import rdcw_pkg::*;

   localparam int TOP_POS      = LENGTH_DEF - 1;
   localparam int TOP_VAL      = VALUES_DEF - 1;
   localparam int DRAIN_CYCLES = 2 * LENGTH_DEF + 16;
   localparam int LIMIT_TIME   = 30_000_000;
   localparam int SEGMENTS     = 3;
   localparam int SEGMENT_LEN  = 88;

   logic               clock         = 1'b0;
   logic               reset         = 1'b1;
   logic               req_valid     = 1'b0;
   logic               req_ready;
   logic               req_opcode    = OP_WRITE;
   logic [INDEX_W-1:0] req_index     = '0;
   logic [INDEX_W-1:0] req_right_end = '0;
   logic [VALUE_W-1:0] req_value     = '0;
   logic               rsp_valid;
   logic               rsp_ready     = 1'b0;
   logic [COUNT_W-1:0] rsp_distinct_count;
   bit                 idle_on       = 1'b1;

   distinct_window_board board = new();

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   range_distinct_count_window_unit u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_opcode         (req_opcode),
      .req_index          (req_index),
      .req_right_end      (req_right_end),
      .req_value          (req_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_distinct_count (rsp_distinct_count)
   );

   // The result side stalls at random unless idling is switched off.
   always @(posedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= !idle_on || ($urandom_range(99) >= 30);
   end

   // Every result item taken is checked against the prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_count(rsp_distinct_count);
   end

   // Offers one item, holds it until accepted, then idles at random.
   task automatic send_item(logic op, logic [INDEX_W-1:0] idx,
                            logic [INDEX_W-1:0] rgt, logic [VALUE_W-1:0] val);
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_index     <= idx;
      req_right_end <= rgt;
      req_value     <= val;
      do
         @(posedge clock);
      while (!req_ready);
      board.take_request(op, idx, rgt, val);
      while (idle_on && $urandom_range(99) < 30) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // The unused field of each item carries random bits.
   task automatic write_value(int unsigned pos, int unsigned val);
      send_item(OP_WRITE, INDEX_W'(pos), INDEX_W'($urandom_range(TOP_POS)), VALUE_W'(val));
   endtask

   task automatic query_range(int unsigned left, int unsigned right);
      send_item(OP_QUERY, INDEX_W'(left), INDEX_W'(right), VALUE_W'($urandom_range(TOP_VAL)));
   endtask

   initial begin
      int unsigned hot_base;
      int unsigned roll;
      int unsigned left;
      int unsigned right;
      int unsigned a;
      int unsigned b;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed items: array ends, extreme values, reversed ranges and
      // writes both inside and outside the window.
      query_range(0, 0);
      query_range(0, TOP_POS);
      write_value(TOP_POS, TOP_VAL);
      write_value(0, TOP_VAL);
      query_range(0, TOP_POS);
      write_value(TOP_POS, 0);
      query_range(TOP_POS, TOP_POS);
      query_range(5, 4);
      query_range(TOP_POS, 0);
      write_value(512, 'hAAA);
      write_value(513, 'h555);
      query_range(510, 515);
      write_value(512, 'h555);
      query_range(512, 513);
      write_value(513, 'hAAA);
      query_range(0, TOP_POS);
      query_range(1, 0);
      query_range(TOP_POS, TOP_POS - 1);
      query_range(600, 599);
      write_value(0, 0);
      write_value(TOP_POS, TOP_VAL);
      query_range(0, 1);
      query_range(TOP_POS - 1, TOP_POS);

      // Random items around a hot region with a small value pool, so that
      // values repeat and tallies often reach and leave zero. The middle
      // segment runs with no idling on either side.
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         if (seg == 0)
            hot_base = 0;
         else if (seg == 1)
            hot_base = $urandom_range(64, LENGTH_DEF - 128);
         else
            hot_base = LENGTH_DEF - 64;
         idle_on <= (seg != 1);
         for (int n = 0; n < SEGMENT_LEN; n++) begin
            roll = $urandom_range(99);
            if (roll < 45) begin
               a = ($urandom_range(99) < 75) ? hot_base + $urandom_range(63)
                                             : $urandom_range(TOP_POS);
               b = ($urandom_range(99) < 70) ? $urandom_range(7) : $urandom_range(TOP_VAL);
               write_value(a, b);
            end else if (roll < 52) begin
               left = $urandom_range(TOP_POS, 1);
               query_range(left, $urandom_range(left - 1));
            end else if (roll < 62) begin
               a = $urandom_range(TOP_POS);
               b = $urandom_range(TOP_POS);
               query_range((a < b) ? a : b, (a < b) ? b : a);
            end else begin
               left  = hot_base + $urandom_range(63);
               right = left + $urandom_range(63);
               if (right > TOP_POS)
                  right = TOP_POS;
               query_range(left, right);
            end
         end
      end
      idle_on <= 1'b1;

      // Drain the results still due, then watch for strays.
      req_valid <= 1'b0;
      while (board.expected_counts.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d writes and %0d queries, %0d of them reversed ranges.",
               board.writes, board.queries, board.reversed);
      $display("%0d distinct counts checked, %0d mismatches.",
               board.checked, board.mismatches);
      if (board.mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #(LIMIT_TIME);
      $display("timeout with %0d results still due", board.expected_counts.size());
      $display("FAIL");
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl
rtl/rdcw_pkg.sv
rtl/rdcw_tally.sv
rtl/range_distinct_count_window_unit.sv
rtl/rdcw_checker.sv
tb/range_distinct_count_window_unit_tb.sv
